>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file of the RTL folder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, switched off while rst is high.
`define MFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on the rising edge of clk that also runs through reset.
`define MFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/mfd_pkg.sv
// Shared constants, widths and types of the motor feedback decoder.
// No dependencies; every module of the block and the testbench import it.
package mfd_pkg;

   localparam int MOTOR_SLOTS_DEF = 6;
   localparam int HISTORY_LEN_DEF = 8;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;
   localparam int TEMP_W      = 8;
   localparam int SLOT_PORT_W = 3;
   localparam int SCALE_W     = 24;
   localparam int TURN_SHIFT  = 13;   // 8192 encoder counts per turn
   localparam int POS_W       = 29;
   localparam int ROTOR_W     = 41;
   localparam int SHAFT_W     = 45;
   localparam int SHAFT_SHIFT = 8;
   localparam int ROTOR_MUL_W = 13;

   localparam logic [SCALE_W-1:0]            SHAFT_SCALE_RST = 24'd38394;
   localparam logic signed [ROTOR_MUL_W-1:0] ROTOR_MUL       = 13'sd2880;
   localparam logic signed [WORD_W-1:0]      STEP_UP_LIM     = -16'sd4000;
   localparam logic signed [WORD_W-1:0]      STEP_DN_LIM     = 16'sd4000;

   typedef struct packed {
      logic signed [WORD_W-1:0] encoder;
      logic signed [WORD_W-1:0] speed;
      logic signed [WORD_W-1:0] current;
      logic signed [TEMP_W-1:0] temp;
   } frame_type;

   // Read launch and write commit strobes toward the per-motor stores.
   typedef struct packed {
      logic rd_en;
      logic commit;
   } store_ctl_type;

endpackage

>>> rtl/core/mfd_slot_store.sv
// Per-motor state memory (last encoder, turn count, speed sum) with its update logic.
// Depends on mfd_pkg.
module mfd_slot_store
   import mfd_pkg::*;
#(
   parameter int MOTOR_SLOTS = MOTOR_SLOTS_DEF,
   parameter int HISTORY_LEN = HISTORY_LEN_DEF,
   localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1,
   localparam int SUM_W  = WORD_W + $clog2(HISTORY_LEN)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  store_ctl_type            ctl,
   input  logic [SLOT_W-1:0]        rd_slot,
   input  logic [SLOT_W-1:0]        wr_slot,
   input  logic signed [WORD_W-1:0] encoder,
   input  logic signed [WORD_W-1:0] speed,
   input  logic signed [WORD_W-1:0] old_speed,
   output logic [WORD_W-1:0]        turns_new,
   output logic signed [SUM_W-1:0]  sum_new
);

   typedef struct packed {
      logic [WORD_W-1:0]        last_enc;
      logic [WORD_W-1:0]        turns;
      logic signed [SUM_W-1:0]  sum;
   } slot_word_type;

   slot_word_type            slot_mem_ff [MOTOR_SLOTS];
   slot_word_type            rd_data_ff;
   slot_word_type            byp_data_ff;
   slot_word_type            cur;
   slot_word_type            wr_data;
   logic [MOTOR_SLOTS-1:0]   vld_ff;
   logic [MOTOR_SLOTS-1:0]   vld_in;
   logic                     rd_vld_ff;
   logic                     byp_ff;
   logic signed [WORD_W-1:0] step;

   // memory: write at commit, registered read at launch
   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         slot_mem_ff[wr_slot] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= slot_mem_ff[rd_slot];
         byp_data_ff <= wr_data;
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (ctl.commit) begin
         vld_in[wr_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         byp_ff    <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (ctl.rd_en) begin
            rd_vld_ff <= vld_ff[rd_slot];
            // forward the word written on the same edge
            byp_ff    <= ctl.commit && (wr_slot == rd_slot);
         end
      end
   end

   always_comb begin
      if (byp_ff) begin
         cur = byp_data_ff;
      end else if (rd_vld_ff) begin
         cur = rd_data_ff;
      end else begin
         cur = '0;
      end
      step             = encoder - cur.last_enc;
      wr_data.last_enc = encoder;
      if (step < STEP_UP_LIM) begin
         wr_data.turns = cur.turns + 16'd1;
      end else if (step > STEP_DN_LIM) begin
         wr_data.turns = cur.turns - 16'd1;
      end else begin
         wr_data.turns = cur.turns;
      end
      wr_data.sum = cur.sum + SUM_W'(speed) - SUM_W'(old_speed);
   end

   assign turns_new = wr_data.turns;
   assign sum_new   = wr_data.sum;

endmodule

>>> rtl/core/mfd_hist_ring.sv
// Speed history ring memory with per-motor write pointers and fill flags.
// Depends on mfd_pkg.
module mfd_hist_ring
   import mfd_pkg::*;
#(
   parameter int MOTOR_SLOTS = MOTOR_SLOTS_DEF,
   parameter int HISTORY_LEN = HISTORY_LEN_DEF,
   localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  store_ctl_type            ctl,
   input  logic [SLOT_W-1:0]        rd_slot,
   input  logic signed [WORD_W-1:0] speed,
   output logic signed [WORD_W-1:0] old_speed
);

   localparam int PTR_W  = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
   localparam int DEPTH  = MOTOR_SLOTS * HISTORY_LEN;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WORD_W-1:0]      hist_mem_ff [DEPTH];
   logic [PTR_W-1:0]       ptr_ff [MOTOR_SLOTS];
   logic [MOTOR_SLOTS-1:0] full_ff;
   logic [WORD_W-1:0]      rd_data_ff;
   logic [WORD_W-1:0]      byp_data_ff;
   logic [ADDR_W-1:0]      wr_addr_ff;
   logic                   rd_vld_ff;
   logic                   byp_ff;
   logic [PTR_W-1:0]       rd_ptr;
   logic [PTR_W-1:0]       ptr_next;
   logic                   ptr_wrap;
   logic [ADDR_W-1:0]      rd_addr;

   assign rd_ptr   = ptr_ff[rd_slot];
   assign ptr_wrap = (rd_ptr == PTR_W'(HISTORY_LEN - 1));
   assign ptr_next = ptr_wrap ? '0 : rd_ptr + 1'b1;
   assign rd_addr  = ADDR_W'(rd_slot) * ADDR_W'(HISTORY_LEN) + ADDR_W'(rd_ptr);

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         hist_mem_ff[wr_addr_ff] <= speed;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= hist_mem_ff[rd_addr];
         byp_data_ff <= speed;
         wr_addr_ff  <= rd_addr;
      end
   end

   // advance the pointer at launch so a following frame sees the next entry
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MOTOR_SLOTS; i++) begin
            ptr_ff[i] <= '0;
         end
         full_ff   <= '0;
         rd_vld_ff <= 1'b0;
         byp_ff    <= 1'b0;
      end else if (ctl.rd_en) begin
         ptr_ff[rd_slot] <= ptr_next;
         if (ptr_wrap) begin
            full_ff[rd_slot] <= 1'b1;
         end
         // the entry under the pointer holds data only once the ring wrapped
         rd_vld_ff <= full_ff[rd_slot];
         byp_ff    <= ctl.commit && (wr_addr_ff == rd_addr);
      end
   end

   always_comb begin
      if (byp_ff) begin
         old_speed = byp_data_ff;
      end else if (rd_vld_ff) begin
         old_speed = rd_data_ff;
      end else begin
         old_speed = '0;
      end
   end

endmodule

>>> rtl/core/mfd_angle_calc.sv
// Multiplier stage: rotor and shaft angle products and the speed average quotient.
// Depends on mfd_pkg.
module mfd_angle_calc
   import mfd_pkg::*;
#(
   parameter int HISTORY_LEN = HISTORY_LEN_DEF,
   localparam int SUM_W = WORD_W + $clog2(HISTORY_LEN)
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [POS_W-1:0]   pos,
   input  logic signed [SUM_W-1:0]   sum,
   input  logic [SCALE_W-1:0]        scale,
   output logic signed [ROTOR_W-1:0] rotor,
   output logic signed [SHAFT_W-1:0] shaft,
   output logic [WORD_W-1:0]         quot,
   output logic                      neg
);

   // reciprocal multiply, exact for every magnitude below 2**SUM_W
   localparam int LOG_L  = $clog2(HISTORY_LEN);
   localparam int DIV_SH = SUM_W + LOG_L;
   localparam int MUL_W  = DIV_SH + 1;
   localparam logic [MUL_W-1:0] DIV_MUL =
      MUL_W'(((64'd1 << DIV_SH) + 64'(HISTORY_LEN) - 64'd1) / 64'(HISTORY_LEN));
   localparam int QPROD_W = SUM_W + MUL_W;
   localparam int SPROD_W = SHAFT_W + SHAFT_SHIFT;

   logic [SUM_W-1:0]          mag;
   logic [QPROD_W-1:0]        qprod;
   logic signed [SPROD_W-1:0] sprod;
   logic signed [ROTOR_W-1:0] rprod;
   logic signed [ROTOR_W-1:0] rotor_ff;
   logic signed [SHAFT_W-1:0] shaft_ff;
   logic [WORD_W-1:0]         quot_ff;
   logic                      neg_ff;

   assign mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
   assign qprod = QPROD_W'(mag) * QPROD_W'(DIV_MUL);
   assign rprod = ROTOR_W'(pos) * ROTOR_W'(ROTOR_MUL);
   assign sprod = SPROD_W'(pos) * SPROD_W'($signed({1'b0, scale}));

   always_ff @(posedge clock) begin
      if (en) begin
         rotor_ff <= rprod;
         // dropping the low bits of a signed product rounds toward minus infinity
         shaft_ff <= sprod[SPROD_W-1:SHAFT_SHIFT];
         quot_ff  <= qprod[DIV_SH +: WORD_W];
         neg_ff   <= sum[SUM_W-1];
      end
   end

   assign rotor = rotor_ff;
   assign shaft = shaft_ff;
   assign quot  = quot_ff;
   assign neg   = neg_ff;

endmodule

>>> rtl/core/motor_feedback_decoder.sv
// Motor feedback decoder top level: frame unpacking, pipeline control, result register.
// Depends on mfd_pkg, mfd_slot_store, mfd_hist_ring and mfd_angle_calc.
//
// Use:
//   Request channel (req_*): one word per feedback frame, the motor slot and seven
//   frame bytes. A word is taken on a rising edge with req_valid high and req_stall low.
//   A word whose slot is not below MOTOR_SLOTS is taken and dropped: no result, no state.
//   Result channel (rsp_*): one word per in-range frame, in arrival order, taken on a
//   rising edge with rsp_valid high and rsp_stall low.
//   CSR channel (csr_*): writes shaft_scale; csr_ready is always high. Write only when
//   no frame is in flight.
// Timing:
//   Sustained rate is one word per clock while rsp_stall is low. An in-range request passes
//   B (slot memory read), C (state update), D (multiplier stage) and O (result register).
//   Per-motor state sits in two memories with a registered read; a same-motor frame right
//   behind another gets the fresh word through a bypass register, so no bubble is needed.
// Reset:
//   Synchronous, active high. Valid bits and ring fill flags clear at once, so all
//   per-motor state reads as zero from the next cycle on; there is no clearing pass.
//   shaft_scale returns to 38394. req_stall is high during reset.
// Stall:
//   While rsp_stall holds a result, the four pipeline registers keep filling; req_stall
//   rises only when all of them are occupied, and follows rsp_stall combinationally.
module motor_feedback_decoder
   import mfd_pkg::*;
#(
   parameter int MOTOR_SLOTS = MOTOR_SLOTS_DEF,
   parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SLOT_PORT_W-1:0]    req_motor_slot,
   input  logic [BYTE_W-1:0]         req_byte0,
   input  logic [BYTE_W-1:0]         req_byte1,
   input  logic [BYTE_W-1:0]         req_byte2,
   input  logic [BYTE_W-1:0]         req_byte3,
   input  logic [BYTE_W-1:0]         req_byte4,
   input  logic [BYTE_W-1:0]         req_byte5,
   input  logic [BYTE_W-1:0]         req_byte6,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SLOT_PORT_W-1:0]    rsp_out_slot,
   output logic signed [WORD_W-1:0]  rsp_encoder_value,
   output logic signed [WORD_W-1:0]  rsp_raw_speed,
   output logic signed [WORD_W-1:0]  rsp_phase_current,
   output logic signed [TEMP_W-1:0]  rsp_temperature,
   output logic signed [WORD_W-1:0]  rsp_turn_total,
   output logic signed [POS_W-1:0]   rsp_position_counts,
   output logic signed [ROTOR_W-1:0] rsp_rotor_angle,
   output logic signed [SHAFT_W-1:0] rsp_output_angle,
   output logic signed [WORD_W-1:0]  rsp_filtered_speed,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [SCALE_W-1:0]        csr_shaft_scale
);

   localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
   localparam int EXT_W  = (SLOT_W > SLOT_PORT_W) ? SLOT_W : SLOT_PORT_W;
   localparam int SUM_W  = WORD_W + $clog2(HISTORY_LEN);

   // ---------------------------------------------------------------- config
   logic [SCALE_W-1:0] scale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SHAFT_SCALE_RST;
      end else if (csr_valid) begin
         scale_ff <= csr_shaft_scale;
      end
   end

   // ---------------------------------------------------------------- control
   // Stages: B (memory read data), C (state updated), D (products), O (result).
   logic          b_vld_ff, c_vld_ff, d_vld_ff, o_vld_ff;
   logic          b_vld_in, c_vld_in, d_vld_in, o_vld_in;
   logic          b_en, c_en, d_en, o_en;
   logic          req_acc;
   logic          in_range;
   store_ctl_type ctl;

   // a stage loads when empty or when its word moves on
   assign o_en = !o_vld_ff || !rsp_stall;
   assign d_en = !d_vld_ff || o_en;
   assign c_en = !c_vld_ff || d_en;
   assign b_en = !b_vld_ff || c_en;

   assign req_stall  = reset || !b_en;
   assign req_acc    = req_valid && !req_stall;
   assign in_range   = (32'(req_motor_slot) < 32'(MOTOR_SLOTS));
   assign ctl.rd_en  = req_acc && in_range;
   // the B word writes back as it leaves for C
   assign ctl.commit = b_vld_ff && c_en;

   assign b_vld_in = b_en ? ctl.rd_en : b_vld_ff;
   assign c_vld_in = c_en ? b_vld_ff  : c_vld_ff;
   assign d_vld_in = d_en ? c_vld_ff  : d_vld_ff;
   assign o_vld_in = o_en ? d_vld_ff  : o_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
         d_vld_ff <= d_vld_in;
         o_vld_ff <= o_vld_in;
      end
   end

   // ---------------------------------------------------------------- unpack
   frame_type         req_frame;
   logic [EXT_W-1:0]  req_slot_ext;
   logic [SLOT_W-1:0] req_idx;

   assign req_frame.encoder = {req_byte0, req_byte1};
   assign req_frame.speed   = {req_byte2, req_byte3};
   assign req_frame.current = {req_byte4, req_byte5};
   assign req_frame.temp    = req_byte6;
   assign req_slot_ext      = EXT_W'(req_motor_slot);
   assign req_idx           = req_slot_ext[SLOT_W-1:0];

   // ---------------------------------------------------------------- stage B
   frame_type                b_frame_ff;
   logic [SLOT_W-1:0]        b_slot_ff;
   logic [WORD_W-1:0]        turns_new;
   logic signed [SUM_W-1:0]  sum_new;
   logic signed [WORD_W-1:0] old_speed;
   logic signed [POS_W-1:0]  b_pos;

   always_ff @(posedge clock) begin
      if (b_en) begin
         b_frame_ff <= req_frame;
         b_slot_ff  <= req_idx;
      end
   end

   mfd_slot_store #(
      .MOTOR_SLOTS (MOTOR_SLOTS),
      .HISTORY_LEN (HISTORY_LEN)
   ) u_slot_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_slot   (req_idx),
      .wr_slot   (b_slot_ff),
      .encoder   (b_frame_ff.encoder),
      .speed     (b_frame_ff.speed),
      .old_speed (old_speed),
      .turns_new (turns_new),
      .sum_new   (sum_new)
   );

   mfd_hist_ring #(
      .MOTOR_SLOTS (MOTOR_SLOTS),
      .HISTORY_LEN (HISTORY_LEN)
   ) u_hist_ring (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_slot   (req_idx),
      .speed     (b_frame_ff.speed),
      .old_speed (old_speed)
   );

   // turns * 8192 + encoder, wrapped to the position width
   assign b_pos = {turns_new, {TURN_SHIFT{1'b0}}} + POS_W'(b_frame_ff.encoder);

   // ---------------------------------------------------------------- stage C
   frame_type               c_frame_ff;
   logic [SLOT_W-1:0]       c_slot_ff;
   logic [WORD_W-1:0]       c_turns_ff;
   logic signed [POS_W-1:0] c_pos_ff;
   logic signed [SUM_W-1:0] c_sum_ff;

   always_ff @(posedge clock) begin
      if (c_en) begin
         c_frame_ff <= b_frame_ff;
         c_slot_ff  <= b_slot_ff;
         c_turns_ff <= turns_new;
         c_pos_ff   <= b_pos;
         c_sum_ff   <= sum_new;
      end
   end

   // ---------------------------------------------------------------- stage D
   frame_type                 d_frame_ff;
   logic [SLOT_W-1:0]         d_slot_ff;
   logic [WORD_W-1:0]         d_turns_ff;
   logic signed [POS_W-1:0]   d_pos_ff;
   logic signed [ROTOR_W-1:0] d_rotor;
   logic signed [SHAFT_W-1:0] d_shaft;
   logic [WORD_W-1:0]         d_quot;
   logic                      d_neg;

   always_ff @(posedge clock) begin
      if (d_en) begin
         d_frame_ff <= c_frame_ff;
         d_slot_ff  <= c_slot_ff;
         d_turns_ff <= c_turns_ff;
         d_pos_ff   <= c_pos_ff;
      end
   end

   mfd_angle_calc #(
      .HISTORY_LEN (HISTORY_LEN)
   ) u_angle_calc (
      .clock (clock),
      .en    (d_en),
      .pos   (c_pos_ff),
      .sum   (c_sum_ff),
      .scale (scale_ff),
      .rotor (d_rotor),
      .shaft (d_shaft),
      .quot  (d_quot),
      .neg   (d_neg)
   );

   // ---------------------------------------------------------------- result
   frame_type                 o_frame_ff;
   logic [SLOT_W-1:0]         o_slot_ff;
   logic [WORD_W-1:0]         o_turns_ff;
   logic signed [POS_W-1:0]   o_pos_ff;
   logic signed [ROTOR_W-1:0] o_rotor_ff;
   logic signed [SHAFT_W-1:0] o_shaft_ff;
   logic [WORD_W-1:0]         o_filt_ff;
   logic [WORD_W-1:0]         o_filt_in;

   // restore the sign: the quotient magnitude already truncates toward zero
   assign o_filt_in = d_neg ? WORD_W'(-d_quot) : d_quot;

   // hold the result word while the receiver stalls
   always_ff @(posedge clock) begin
      if (o_en) begin
         o_frame_ff <= d_frame_ff;
         o_slot_ff  <= d_slot_ff;
         o_turns_ff <= d_turns_ff;
         o_pos_ff   <= d_pos_ff;
         o_rotor_ff <= d_rotor;
         o_shaft_ff <= d_shaft;
         o_filt_ff  <= o_filt_in;
      end
   end

   assign rsp_valid           = o_vld_ff;
   assign rsp_out_slot        = SLOT_PORT_W'(o_slot_ff);
   assign rsp_encoder_value   = o_frame_ff.encoder;
   assign rsp_raw_speed       = o_frame_ff.speed;
   assign rsp_phase_current   = o_frame_ff.current;
   assign rsp_temperature     = o_frame_ff.temp;
   assign rsp_turn_total      = o_turns_ff;
   assign rsp_position_counts = o_pos_ff;
   assign rsp_rotor_angle     = o_rotor_ff;
   assign rsp_output_angle    = o_shaft_ff;
   assign rsp_filtered_speed  = o_filt_ff;

endmodule

>>> rtl/core/mfd_checker.sv
// Port-level checker for the motor feedback decoder, bound to the top level.
// Depends on mfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mfd_checker
   import mfd_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [SLOT_PORT_W-1:0]    rsp_out_slot,
   input logic signed [WORD_W-1:0]  rsp_encoder_value,
   input logic signed [WORD_W-1:0]  rsp_turn_total,
   input logic signed [POS_W-1:0]   rsp_position_counts,
   input logic signed [ROTOR_W-1:0] rsp_rotor_angle
);

   `MFD_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> !rsp_valid, "result valid right after reset")

   `MFD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "stalled result dropped")

   `MFD_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_out_slot) && $stable(rsp_turn_total) && $stable(rsp_encoder_value), "stalled result changed")

   `MFD_ASSERT(a_pos_match, clock, reset, rsp_valid |-> rsp_position_counts == ({rsp_turn_total, {TURN_SHIFT{1'b0}}} + {{(POS_W-WORD_W){rsp_encoder_value[WORD_W-1]}}, rsp_encoder_value}), "position does not match turns and encoder")

   `MFD_ASSERT(a_rotor_match, clock, reset, rsp_valid |-> rsp_rotor_angle == (ROTOR_W'(rsp_position_counts) * ROTOR_W'(ROTOR_MUL)), "rotor angle does not match position")

endmodule

bind motor_feedback_decoder mfd_checker u_mfd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_out_slot        (rsp_out_slot),
   .rsp_encoder_value   (rsp_encoder_value),
   .rsp_turn_total      (rsp_turn_total),
   .rsp_position_counts (rsp_position_counts),
   .rsp_rotor_angle     (rsp_rotor_angle)
);

>>> tb/motor_feedback_decoder_test.sv
// Self-checking testbench for motor_feedback_decoder: directed frames, a turn-count sweep
// and random frames under sender idling and receiver stalls, checked against a predictor.
// Depends on mfd_pkg and the motor_feedback_decoder RTL.
`timescale 1ns / 100ps

module motor_feedback_decoder_test;
   import mfd_pkg::*;

   // Decoder arithmetic as the frame format defines it.
   localparam int     TURN_STEP_LIMIT = 4000;
   localparam longint COUNTS_PER_TURN = 8192;
   localparam longint ROTOR_DEG_Q16   = 2880;   // 360/8192 degrees per count, Q16.16
   localparam int     ENC_MASK        = 8191;

   // Run shape.
   localparam int ITEMS_PER_PHASE = 160;
   localparam int SWEEP_FRAMES    = 100;    // one turn-up per frame
   localparam logic [SLOT_PORT_W-1:0] SWEEP_SLOT = 3'd3;
   localparam int DRAIN_CYCLES    = 8;      // results pass stages B, C, D and O
   localparam int CYCLE_LIMIT     = 600000;

   // One result word, fields named after the rsp_ ports.
   typedef struct {
      logic [SLOT_PORT_W-1:0]    out_slot;
      logic signed [WORD_W-1:0]  encoder_value;
      logic signed [WORD_W-1:0]  raw_speed;
      logic signed [WORD_W-1:0]  phase_current;
      logic signed [TEMP_W-1:0]  temperature;
      logic signed [WORD_W-1:0]  turn_total;
      logic signed [POS_W-1:0]   position_counts;
      logic signed [ROTOR_W-1:0] rotor_angle;
      logic signed [SHAFT_W-1:0] output_angle;
      logic signed [WORD_W-1:0]  filtered_speed;
   } feedback_word_type;

   // Per-motor decoder state mirrored in the testbench; predicts one result word per
   // accepted in-range frame and checks result words against them in order.
   class feedback_scoreboard;
      logic [SCALE_W-1:0]       shaft_scale;
      logic signed [WORD_W-1:0] last_encoder [MOTOR_SLOTS_DEF];
      logic signed [WORD_W-1:0] turn_count [MOTOR_SLOTS_DEF];
      int                       speed_ring [MOTOR_SLOTS_DEF][HISTORY_LEN_DEF];
      int                       ring_ptr [MOTOR_SLOTS_DEF];
      int                       speed_sum [MOTOR_SLOTS_DEF];
      feedback_word_type        expected_words [$];
      int                       failures;

      function new();
         shaft_scale = SHAFT_SCALE_RST;
         failures = 0;
         foreach (last_encoder[s]) begin
            last_encoder[s] = '0;
            turn_count[s] = '0;
            ring_ptr[s] = 0;
            speed_sum[s] = 0;
         end
         foreach (speed_ring[s, k]) speed_ring[s][k] = 0;
      endfunction

      // Frame bytes packed big-endian: byte0 in the top eight bits.
      function void note_frame(logic [SLOT_PORT_W-1:0] slot, logic [55:0] frame_bytes);
         feedback_word_type        w;
         logic signed [WORD_W-1:0] step;
         longint                   pos_wide;
         longint                   product;
         int                       m;
         if (slot >= MOTOR_SLOTS_DEF) return;   // dropped by the block, no state touched
         m = int'(slot);
         w.out_slot = slot;
         w.encoder_value = frame_bytes[55:40];
         w.raw_speed = frame_bytes[39:24];
         w.phase_current = frame_bytes[23:8];
         w.temperature = frame_bytes[7:0];

         // Step wraps to 16 bits before the threshold compare.
         step = w.encoder_value - last_encoder[m];
         last_encoder[m] = w.encoder_value;
         if (step < -TURN_STEP_LIMIT) turn_count[m] = turn_count[m] + 16'sd1;
         else if (step > TURN_STEP_LIMIT) turn_count[m] = turn_count[m] - 16'sd1;
         w.turn_total = turn_count[m];

         // Position wraps to 29 bits; both angles come from the wrapped value.
         pos_wide = longint'(w.turn_total) * COUNTS_PER_TURN + longint'(w.encoder_value);
         w.position_counts = pos_wide[POS_W-1:0];
         w.rotor_angle = ROTOR_W'(longint'(w.position_counts) * ROTOR_DEG_Q16);
         product = longint'(w.position_counts) * longint'({1'b0, shaft_scale});
         w.output_angle = SHAFT_W'(product >>> SHAFT_SHIFT);   // floor toward minus infinity

         speed_sum[m] += int'(w.raw_speed) - speed_ring[m][ring_ptr[m]];
         speed_ring[m][ring_ptr[m]] = int'(w.raw_speed);
         ring_ptr[m] = (ring_ptr[m] + 1) % HISTORY_LEN_DEF;
         w.filtered_speed = WORD_W'(speed_sum[m] / HISTORY_LEN_DEF);   // truncates toward zero

         expected_words.push_back(w);
      endfunction

      function void compare_field(string field, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_result(feedback_word_type got);
         feedback_word_type want;
         if (expected_words.size() == 0) begin
            $error("out_slot: expected no word, got %0d", got.out_slot);
            failures++;
            return;
         end
         want = expected_words.pop_front();
         compare_field("out_slot", want.out_slot, got.out_slot);
         compare_field("encoder_value", want.encoder_value, got.encoder_value);
         compare_field("raw_speed", want.raw_speed, got.raw_speed);
         compare_field("phase_current", want.phase_current, got.phase_current);
         compare_field("temperature", want.temperature, got.temperature);
         compare_field("turn_total", want.turn_total, got.turn_total);
         compare_field("position_counts", want.position_counts, got.position_counts);
         compare_field("rotor_angle", want.rotor_angle, got.rotor_angle);
         compare_field("output_angle", want.output_angle, got.output_angle);
         compare_field("filtered_speed", want.filtered_speed, got.filtered_speed);
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [SLOT_PORT_W-1:0]    req_motor_slot;
   logic [BYTE_W-1:0]         req_byte0, req_byte1, req_byte2, req_byte3;
   logic [BYTE_W-1:0]         req_byte4, req_byte5, req_byte6;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [SLOT_PORT_W-1:0]    rsp_out_slot;
   logic signed [WORD_W-1:0]  rsp_encoder_value;
   logic signed [WORD_W-1:0]  rsp_raw_speed;
   logic signed [WORD_W-1:0]  rsp_phase_current;
   logic signed [TEMP_W-1:0]  rsp_temperature;
   logic signed [WORD_W-1:0]  rsp_turn_total;
   logic signed [POS_W-1:0]   rsp_position_counts;
   logic signed [ROTOR_W-1:0] rsp_rotor_angle;
   logic signed [SHAFT_W-1:0] rsp_output_angle;
   logic signed [WORD_W-1:0]  rsp_filtered_speed;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [SCALE_W-1:0]        csr_shaft_scale;

   feedback_scoreboard sb;

   // Traffic shaping knobs, set per phase.
   int idle_pct;
   int stall_pct;
   int cycle_count;

   // Stimulus memory for well-formed encoder and speed sequences per motor.
   int enc_track [MOTOR_SLOTS_DEF];
   int speed_track [MOTOR_SLOTS_DEF];

   motor_feedback_decoder dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_motor_slot      (req_motor_slot),
      .req_byte0           (req_byte0),
      .req_byte1           (req_byte1),
      .req_byte2           (req_byte2),
      .req_byte3           (req_byte3),
      .req_byte4           (req_byte4),
      .req_byte5           (req_byte5),
      .req_byte6           (req_byte6),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_slot        (rsp_out_slot),
      .rsp_encoder_value   (rsp_encoder_value),
      .rsp_raw_speed       (rsp_raw_speed),
      .rsp_phase_current   (rsp_phase_current),
      .rsp_temperature     (rsp_temperature),
      .rsp_turn_total      (rsp_turn_total),
      .rsp_position_counts (rsp_position_counts),
      .rsp_rotor_angle     (rsp_rotor_angle),
      .rsp_output_angle    (rsp_output_angle),
      .rsp_filtered_speed  (rsp_filtered_speed),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_shaft_scale     (csr_shaft_scale)
   );

   always #2 clock = ~clock;

   // Receiver: pick a new stall level every cycle, away from the sampling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Check every result word the receiver takes.
   always @(posedge clock) begin
      feedback_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.out_slot = rsp_out_slot;
         got.encoder_value = rsp_encoder_value;
         got.raw_speed = rsp_raw_speed;
         got.phase_current = rsp_phase_current;
         got.temperature = rsp_temperature;
         got.turn_total = rsp_turn_total;
         got.position_counts = rsp_position_counts;
         got.rotor_angle = rsp_rotor_angle;
         got.output_angle = rsp_output_angle;
         got.filtered_speed = rsp_filtered_speed;
         sb.check_result(got);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("motor_feedback_decoder_test: done, errors");
         $finish;
      end
   end

   // Offer one request word, with random idle cycles in front, and hold it until the
   // block takes it. Leaves req_valid high on return.
   task automatic push_frame(input logic [SLOT_PORT_W-1:0] slot, input logic [55:0] frame_bytes);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_motor_slot <= slot;
      {req_byte0, req_byte1, req_byte2, req_byte3, req_byte4, req_byte5, req_byte6}
         <= frame_bytes;
      do @(posedge clock); while (req_stall);
      sb.note_frame(slot, frame_bytes);
   endtask

   task automatic send_fields(input logic [SLOT_PORT_W-1:0] slot, input logic [15:0] enc,
                              input logic [15:0] spd, input logic [15:0] cur,
                              input logic [7:0] temp);
      push_frame(slot, {enc, spd, cur, temp});
   endtask

   // Drop valid and wait until every expected word is back and the pipe is empty,
   // dropped frames included.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_shaft_scale(input logic [SCALE_W-1:0] scale);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_shaft_scale <= scale;
      do @(posedge clock); while (!csr_ready);
      sb.shaft_scale = scale;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      idle_pct = 0;
      stall_pct = 0;
      // First frame of a motor compares against a zero encoder.
      send_fields(3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      // Step of +8191 counts a turn down and gives a negative position; back again.
      send_fields(3'd1, 16'h1FFF, 16'h7FFF, 16'h7FFF, 8'h7F);
      send_fields(3'd1, 16'h0000, 16'h8000, 16'h8000, 8'h80);
      // Steps of exactly 4000 stay put, 4001 counts.
      send_fields(3'd1, 16'd4000, 16'h0100, 16'h00FF, 8'h19);
      send_fields(3'd1, 16'd0, 16'hFF00, 16'hFF01, 8'hE7);
      send_fields(3'd1, 16'd4001, 16'h0001, 16'h0002, 8'h01);
      send_fields(3'd1, 16'd0, 16'hFFFE, 16'hFFFD, 8'hFE);
      // Encoder step wraps through the 16-bit sign boundary.
      send_fields(3'd2, 16'h8000, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_fields(3'd2, 16'h7FFF, 16'h0001, 16'h0001, 8'h01);
      send_fields(3'd2, 16'hFFFF, 16'h5555, 16'hAAAA, 8'h55);
      // Out-of-range motors 6 and 7: taken and dropped; motor 5 is in range.
      send_fields(3'd6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_fields(3'd7, 16'h1FFF, 16'h7FFF, 16'h8000, 8'hAA);
      send_fields(3'd5, 16'h1234, 16'h5678, 16'h9ABC, 8'hDE);
      // Fill the speed ring with -1 (average truncates to zero until -8), then overwrite
      // the oldest entry on the ninth frame.
      for (int i = 0; i < HISTORY_LEN_DEF + 1; i++)
         send_fields(3'd4, 16'(16 * i), (i == HISTORY_LEN_DEF) ? 16'd100 : 16'hFFFF,
                     16'(i), 8'(i));
   endtask

   // Every frame steps the encoder back by more than the limit, so the turn count
   // climbs by one per frame.
   task automatic run_turn_sweep();
      logic [15:0] enc;
      enc = 16'h0000;
      idle_pct = 0;
      stall_pct = 0;
      repeat (SWEEP_FRAMES) begin
         enc = enc - 16'($urandom_range(20000, TURN_STEP_LIMIT + 1));
         push_frame(SWEEP_SLOT, {enc, 16'($urandom()), 16'($urandom()), 8'($urandom())});
      end
   endtask

   // Mostly well-formed encoder tracks (small moves over the 13-bit range, so wraps
   // count turns), plus raw random frames and a few out-of-range motors.
   task automatic run_random_phase(input int sender_idle, input int receiver_stall);
      int                     counted;
      int                     choice;
      logic [SLOT_PORT_W-1:0] slot;
      logic [55:0]            frame_bytes;
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
         choice = int'($urandom_range(99));
         frame_bytes = 56'({$urandom(), $urandom()});
         if (choice < 5) begin
            slot = 3'($urandom_range(7, MOTOR_SLOTS_DEF));
         end else begin
            slot = 3'($urandom_range(MOTOR_SLOTS_DEF - 1));
            counted++;
            if (choice >= 15) begin
               if ($urandom_range(9) == 0)
                  enc_track[slot] = int'($urandom_range(ENC_MASK));
               else
                  enc_track[slot] = int'((enc_track[slot] + $urandom_range(6000) - 3000)
                                         & ENC_MASK);
               if ($urandom_range(19) == 0)
                  speed_track[slot] = int'($urandom_range(65535) - 32768);
               else
                  speed_track[slot] = int'(speed_track[slot] + $urandom_range(400) - 200);
               frame_bytes[55:40] = 16'(enc_track[slot]);
               frame_bytes[39:24] = 16'(speed_track[slot]);
            end
         end
         push_frame(slot, frame_bytes);
      end
   endtask

   initial begin
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      cycle_count = 0;
      idle_pct = 0;
      stall_pct = 0;
      req_valid = 1'b0;
      req_motor_slot = '0;
      {req_byte0, req_byte1, req_byte2, req_byte3, req_byte4, req_byte5, req_byte6} = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_shaft_scale = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames run at the reset scale.
      run_directed();

      // Largest scale gives the widest shaft products.
      write_shaft_scale({SCALE_W{1'b1}});
      run_turn_sweep();

      write_shaft_scale('0);
      run_random_phase(0, 0);
      write_shaft_scale(24'($urandom()));
      run_random_phase(88, 0);
      write_shaft_scale(24'd1);
      run_random_phase(0, 88);
      write_shaft_scale(24'($urandom()));
      run_random_phase(22, 22);

      wait_drained();
      if (sb.failures == 0 && sb.expected_words.size() == 0)
         $display("motor_feedback_decoder_test: done, clean");
      else
         $display("motor_feedback_decoder_test: done, errors");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mfd_pkg.sv
rtl/core/mfd_slot_store.sv
rtl/core/mfd_hist_ring.sv
rtl/core/mfd_angle_calc.sv
rtl/core/motor_feedback_decoder.sv
rtl/core/mfd_checker.sv
tb/motor_feedback_decoder_test.sv
